FILE: src/circular_double_ended_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular double-ended queue unit
// Shared concurrent checks; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
`define CDEQ_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("cdeq: forbidden condition seen");
`define CDEQ_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cdeq: implication failed");
`define CDEQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cdeq: next-cycle implication failed");
`else
`define CDEQ_ASSERT_NEVER(lbl, cond)
`define CDEQ_ASSERT_IMPLY(lbl, ante, cons)
`define CDEQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/cdeq_pkg.sv
// ----------------------------------------------------------------------------
// cdeq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdeq_pkg;

   localparam int unsigned DEFAULT_MAX_CAPACITY = 1023;
   localparam int unsigned CAP_W                = 10;
   localparam int unsigned WORD_W               = 32;
   localparam int unsigned KIND_W               = 3;
   localparam int unsigned CSR_DATA_W           = 32;
   localparam int unsigned CSR_ADDR_W           = 3;
   localparam int unsigned CSR_INDEX_W          = 1;
   localparam logic [CAP_W-1:0] CAP_RESET       = 10'd1023;
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_QUERY      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic     en;
      logic     clear;
      kind_type kind;
   } ctrl_type;

   typedef struct packed {
      logic ok;
      logic empty;
      logic full;
   } status_type;

endpackage

`default_nettype wire

FILE: src/cdeq_ring_mem.sv
// ----------------------------------------------------------------------------
// cdeq_ring_mem
// Ring storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_double_ended_queue_unit_macros.svh"

module cdeq_ring_mem #(
   parameter int unsigned DEPTH = cdeq_pkg::DEFAULT_MAX_CAPACITY + 1,
   parameter int unsigned IDX_W = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [IDX_W-1:0]            wr_addr,
   input  wire logic [cdeq_pkg::WORD_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [IDX_W-1:0]            rd_a_addr,
   input  wire logic [IDX_W-1:0]            rd_b_addr,
   output logic      [cdeq_pkg::WORD_W-1:0] rd_a_data,
   output logic      [cdeq_pkg::WORD_W-1:0] rd_b_data
);
   import cdeq_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_a_addr];
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

   `CDEQ_ASSERT_NEVER(a_no_rd_wr_overlap, wr_en && rd_en)

endmodule

`default_nettype wire

FILE: src/cdeq_index.sv
// ----------------------------------------------------------------------------
// cdeq_index
// Front and back indices, ring wrap arithmetic and empty/full status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "circular_double_ended_queue_unit_macros.svh"

module cdeq_index #(
   parameter int unsigned MAX_CAPACITY = cdeq_pkg::DEFAULT_MAX_CAPACITY,
   parameter int unsigned IDX_W        = $clog2(MAX_CAPACITY + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [cdeq_pkg::CAP_W-1:0] capacity,
   input  wire cdeq_pkg::ctrl_type         ctrl,
   output cdeq_pkg::status_type            status,
   output logic                            wr_en,
   output logic      [IDX_W-1:0]           wr_addr,
   output logic      [IDX_W-1:0]           front_addr,
   output logic      [IDX_W-1:0]           rear_addr
);
   import cdeq_pkg::*;

   localparam int unsigned CMP_W = (IDX_W > CAP_W) ? IDX_W : CAP_W;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_CAPACITY);

   logic [IDX_W-1:0] front_ff;
   logic [IDX_W-1:0] front_in;
   logic [IDX_W-1:0] back_ff;
   logic [IDX_W-1:0] back_in;
   logic [CMP_W-1:0] cap_ext;
   logic [IDX_W-1:0] cap_eff;
   logic             empty;
   logic             full;
   logic             ok;
   logic             push_ok;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] last);
      return (x >= last) ? '0 : IDX_W'(x + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] last);
      return ((x == '0) || (x > last)) ? last : IDX_W'(x - 1'b1);
   endfunction

   always_comb begin
      cap_ext = CMP_W'(capacity);
      priority if (cap_ext == '0) begin
         cap_eff = IDX_W'(1);
      end else if (cap_ext > MAX_EXT) begin
         cap_eff = IDX_W'(MAX_EXT);
      end else begin
         cap_eff = IDX_W'(cap_ext);
      end
   end

   always_comb begin
      empty    = (front_ff == back_ff);
      full     = (ring_next(back_ff, cap_eff) == front_ff);
      front_in = front_ff;
      back_in  = back_ff;
      ok       = 1'b0;
      push_ok  = 1'b0;
      wr_addr  = back_ff;
      unique case (ctrl.kind)
         KIND_PUSH_FRONT: begin
            if (!full) begin
               front_in = ring_prev(front_ff, cap_eff);
               wr_addr  = front_in;
               push_ok  = 1'b1;
               ok       = 1'b1;
            end
         end
         KIND_PUSH_BACK: begin
            if (!full) begin
               back_in = ring_next(back_ff, cap_eff);
               push_ok = 1'b1;
               ok      = 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (!empty) begin
               front_in = ring_next(front_ff, cap_eff);
               ok       = 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (!empty) begin
               back_in = ring_prev(back_ff, cap_eff);
               ok      = 1'b1;
            end
         end
         KIND_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         front_ff <= '0;
         back_ff  <= '0;
      end else if (ctrl.en) begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   assign wr_en        = ctrl.en && push_ok;
   assign front_addr   = front_ff;
   assign rear_addr    = ring_prev(back_ff, cap_eff);
   assign status.ok    = ok;
   assign status.empty = empty;
   assign status.full  = full;

   `CDEQ_ASSERT_NEVER(a_empty_and_full, empty && full)
   `CDEQ_ASSERT_NEVER(a_index_in_ring, (front_ff > cap_eff) || (back_ff > cap_eff))
   `CDEQ_ASSERT_NEVER(a_en_with_clear, ctrl.en && ctrl.clear)

endmodule

`default_nettype wire

FILE: src/circular_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Double-ended queue of signed 32-bit words kept in a ring memory.
// ----------------------------------------------------------------------------
// Each request item is one operation (push front, push back, pop front, pop
// back, query) and yields exactly one response item with ok, empty and full
// flags and the front and rear words (all ones when empty). An item is taken
// in one cycle that updates the indices and writes a pushed word, the next
// cycle reads the front and rear words from the ring memory, and the cycle
// after that loads the response register, once it is free, while it can
// already take the next item; no new item is taken while one is still being
// read, and a stalled response holds off the next request. Writing the
// capacity register empties the queue; the stored words are kept, and the
// memory needs no clearing pass after reset.
`default_nettype none
`include "circular_double_ended_queue_unit_macros.svh"

module circular_double_ended_queue_unit #(
   parameter int unsigned MAX_CAPACITY = cdeq_pkg::DEFAULT_MAX_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: value[31:0]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [31:0]                     req_tdata,
   // req_tuser: kind[2:0]
   input  wire logic [2:0]                      req_tuser,
   // rsp_tdata: ok[0], is_empty[1], is_full[2], front_value[34:3],
   //            rear_value[66:35], zero[71:67]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [71:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cdeq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cdeq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cdeq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import cdeq_pkg::*;

   localparam int unsigned DEPTH   = MAX_CAPACITY + 1;
   localparam int unsigned IDX_W   = $clog2(DEPTH);
   localparam int unsigned RSP_PAD = 72 - (3 + 2 * WORD_W);

   state_type         state_ff;
   state_type         state_in;
   logic [CAP_W-1:0]  capacity_ff;
   logic              ok_ff;
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic              rsp_empty_ff;
   logic              rsp_full_ff;
   logic [WORD_W-1:0] rsp_front_ff;
   logic [WORD_W-1:0] rsp_rear_ff;

   logic              req_accept;
   logic              rd_en;
   logic              out_load;
   logic              csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   ctrl_type          ctrl;
   status_type        status;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  front_addr;
   logic [IDX_W-1:0]  rear_addr;
   logic [WORD_W-1:0] rd_front;
   logic [WORD_W-1:0] rd_rear;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write && (csr_index == REG_CAPACITY)) begin
         capacity_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rd_en      = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            out_load   = !rsp_valid_ff || rsp_tready;
            req_tready = out_load;
            if (out_load) begin
               state_in = req_tvalid ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctrl.en    = req_accept;
   assign ctrl.clear = csr_write && (csr_index == REG_CAPACITY);
   assign ctrl.kind  = kind_type'(req_tuser);

   cdeq_index #(
      .MAX_CAPACITY(MAX_CAPACITY),
      .IDX_W       (IDX_W)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .ctrl      (ctrl),
      .status    (status),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .front_addr(front_addr),
      .rear_addr (rear_addr)
   );

   cdeq_ring_mem #(
      .DEPTH(DEPTH),
      .IDX_W(IDX_W)
   ) u_ring_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_tdata),
      .rd_en    (rd_en),
      .rd_a_addr(front_addr),
      .rd_b_addr(rear_addr),
      .rd_a_data(rd_front),
      .rd_b_data(rd_rear)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ok_ff <= status.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_empty_ff <= status.empty;
         rsp_full_ff  <= status.full;
         rsp_front_ff <= status.empty ? '1 : rd_front;
         rsp_rear_ff  <= status.empty ? '1 : rd_rear;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_rear_ff, rsp_front_ff,
                        rsp_full_ff, rsp_empty_ff, rsp_ok_ff};

   `CDEQ_ASSERT_NEXT(a_accept_starts_read, req_accept, state_ff == ST_READ)
   `CDEQ_ASSERT_NEXT(a_read_then_load, state_ff == ST_READ, state_ff == ST_LOAD)
   `CDEQ_ASSERT_IMPLY(a_load_accept_drains, (state_ff == ST_LOAD) && req_accept, out_load)
   `CDEQ_ASSERT_NEXT(a_load_sets_valid, out_load, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: tb/deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request, response and register ports of the double-ended queue
// unit. It keeps its own ring, indices and capacity, and works out the status
// item that each accepted request must yield. Each response item is compared
// field by field, in order, with the oldest status still owed. A read of the
// capacity register is checked against the last value written or the reset value.
// ----------------------------------------------------------------------------
module deque_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [31:0]                     req_tdata,
   input  wire logic [cdeq_pkg::KIND_W-1:0]     req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [71:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cdeq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cdeq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [cdeq_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   failures,
   output int                                   pending
);
   import cdeq_pkg::*;

   localparam int unsigned RING_DEPTH = DEFAULT_MAX_CAPACITY + 1;

   typedef struct packed {
      logic              ok;
      logic              empty;
      logic              full;
      logic [WORD_W-1:0] front;
      logic [WORD_W-1:0] rear;
   } deque_status_type;

   deque_status_type  owed_status_q [$];
   logic [WORD_W-1:0] ring_mem [0:RING_DEPTH-1];
   int unsigned       front_idx = 0;
   int unsigned       back_idx = 0;
   logic [CAP_W-1:0]  cap_reg = CAP_RESET;

   initial begin
      failures = 0;
      pending = 0;
   end

   function automatic int unsigned step_up(input int unsigned x, input int unsigned slots);
      return (x + 1 >= slots) ? 0 : x + 1;
   endfunction

   function automatic int unsigned step_down(input int unsigned x, input int unsigned slots);
      return (x == 0 || x >= slots) ? slots - 1 : x - 1;
   endfunction

   task automatic predict_deque_op(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word);
      int unsigned      eff;
      int unsigned      slots;
      logic             was_empty;
      logic             was_full;
      deque_status_type st;
      eff = cap_reg;
      if (eff < 1) eff = 1;
      if (eff > DEFAULT_MAX_CAPACITY) eff = DEFAULT_MAX_CAPACITY;
      slots = eff + 1;
      was_empty = (front_idx == back_idx);
      was_full = (step_up(back_idx, slots) == front_idx);
      st.ok = 1'b0;
      case (op)
         KIND_PUSH_FRONT: begin
            if (!was_full) begin
               front_idx = step_down(front_idx, slots);
               ring_mem[front_idx % RING_DEPTH] = word;
               st.ok = 1'b1;
            end
         end
         KIND_PUSH_BACK: begin
            if (!was_full) begin
               ring_mem[back_idx % RING_DEPTH] = word;
               back_idx = step_up(back_idx, slots);
               st.ok = 1'b1;
            end
         end
         KIND_POP_FRONT: begin
            if (!was_empty) begin
               front_idx = step_up(front_idx, slots);
               st.ok = 1'b1;
            end
         end
         KIND_POP_BACK: begin
            if (!was_empty) begin
               back_idx = step_down(back_idx, slots);
               st.ok = 1'b1;
            end
         end
         KIND_QUERY: st.ok = 1'b1;
         default: st.ok = 1'b0;
      endcase
      st.empty = (front_idx == back_idx);
      st.full = (step_up(back_idx, slots) == front_idx);
      if (st.empty) begin
         st.front = '1;
         st.rear = '1;
      end else begin
         st.front = ring_mem[front_idx % RING_DEPTH];
         st.rear = ring_mem[step_down(back_idx, slots) % RING_DEPTH];
      end
      owed_status_q.push_back(st);
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      deque_status_type want;
      if (reset) begin
         front_idx = 0;
         back_idx = 0;
         cap_reg = CAP_RESET;
         owed_status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_status_q.size() == 0) begin
               $display("%0t: response item with none expected, actual %h", $time, rsp_tdata);
               failures++;
            end else begin
               want = owed_status_q.pop_front();
               check_field("ok", WORD_W'(want.ok), WORD_W'(rsp_tdata[0]));
               check_field("is_empty", WORD_W'(want.empty), WORD_W'(rsp_tdata[1]));
               check_field("is_full", WORD_W'(want.full), WORD_W'(rsp_tdata[2]));
               check_field("front_value", want.front, rsp_tdata[34:3]);
               check_field("rear_value", want.rear, rsp_tdata[66:35]);
            end
         end
         if (req_tvalid && req_tready)
            predict_deque_op(req_tuser, req_tdata);
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) begin
            if (csr_pwrite) begin
               cap_reg = csr_pwdata[CAP_W-1:0];
               front_idx = 0;
               back_idx = 0;
            end else if (csr_prdata !== {{(CSR_DATA_W-CAP_W){1'b0}}, cap_reg}) begin
               $display("%0t: capacity read mismatch, expected %h actual %h", $time,
                        {{(CSR_DATA_W-CAP_W){1'b0}}, cap_reg}, csr_prdata);
               failures++;
            end
         end
      end
      pending = owed_status_q.size();
   end

endmodule

FILE: tb/tb_circular_double_ended_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_double_ended_queue_unit
// Drives push, pop, query and unknown operations into the deque unit under
// several capacities, from the smallest to the largest, with random gaps on
// the request side and random stalls on the response side. A checker beside
// the unit predicts and compares every response item.
// ----------------------------------------------------------------------------
module tb_circular_double_ended_queue_unit;
   import cdeq_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
   localparam int SESSIONS = 12;
   localparam int SESSION_ITEMS = 108;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [71:0]           rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending;
   int                    snd_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    hold_seq = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;

   circular_double_ended_queue_unit dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   deque_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .failures, .pending
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] op, input logic [WORD_W-1:0] word);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_paddr <= CAP_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-CAP_W){1'b0}}, cap};
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0]  cap;
      logic [KIND_W-1:0] op;
      logic [WORD_W-1:0] word;
      int                eff_cap;
      int                fill_pct;
      int                bias_left;
      int                run_max;
      int                r;

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(KIND_QUERY, WORD_ONES);
      send_item(KIND_POP_FRONT, WORD_MAX);
      send_item(KIND_POP_BACK, WORD_MIN);
      send_item(KIND_PUSH_FRONT, WORD_MAX);
      send_item(KIND_PUSH_BACK, WORD_MIN);
      send_item(KIND_PUSH_FRONT, '0);
      send_item(KIND_PUSH_BACK, WORD_ONES);
      send_item(KIND_UNUSED_LO, 32'h1234_5678);
      send_item(KIND_UNUSED_LO + 3'd1, 32'h5555_AAAA);
      send_item(KIND_UNUSED_HI, 32'hAAAA_5555);
      send_item(KIND_POP_FRONT, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_POP_FRONT, '0);
      wait_drained();
      write_capacity('0);
      send_item(KIND_PUSH_BACK, 32'h0F0F_F0F0);
      send_item(KIND_PUSH_FRONT, WORD_MAX);
      send_item(KIND_PUSH_BACK, WORD_MIN);
      send_item(KIND_QUERY, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_POP_FRONT, '0);

      for (int s = 0; s < SESSIONS; s++) begin
         wait_drained();
         case (s)
            0: cap = 10'd2;
            1: cap = 10'd1;
            2: cap = 10'd3;
            3: cap = 10'd1023;
            4: cap = 10'd5;
            5: cap = 10'd0;
            6: cap = 10'd8;
            7: cap = 10'd17;
            8: cap = 10'd4;
            9: cap = 10'd512;
            10: cap = 10'd6;
            default: cap = 10'd1023;
         endcase
         write_capacity(cap);
         case (s % 4)
            0: begin
               snd_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               snd_idle_pct = 65;
               rsp_stall_pct = 0;
            end
            2: begin
               snd_idle_pct = 0;
               rsp_stall_pct = 65;
            end
            default: begin
               snd_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase
         eff_cap = (cap == 0) ? 1 : int'(cap);
         run_max = (eff_cap * 2 + 6 > 60) ? 60 : eff_cap * 2 + 6;
         fill_pct = 25;
         bias_left = 0;
         for (int n = 0; n < SESSION_ITEMS; n++) begin
            if (s == 4 && n == 20)
               hold_seq++;
            if (s == 8 && n == 50)
               wait_drained();
            if (bias_left == 0) begin
               fill_pct = (fill_pct > 50) ? 25 : 80;
               bias_left = int'($urandom_range(2, run_max));
            end
            bias_left--;
            r = int'($urandom_range(0, 99));
            if (r < 4)
               op = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else if (r < 12)
               op = KIND_QUERY;
            else if ($urandom_range(0, 99) < fill_pct)
               op = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
            case ($urandom_range(0, 15))
               0: word = WORD_MIN;
               1: word = WORD_MAX;
               2: word = '0;
               3: word = WORD_ONES;
               default: word = $urandom;
            endcase
            send_item(op, word);
         end
      end

      wait_drained();
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/cdeq_pkg.sv
src/cdeq_ring_mem.sv
src/cdeq_index.sv
src/circular_double_ended_queue_unit.sv
tb/deque_checker.sv
tb/tb_circular_double_ended_queue_unit.sv
